// File: rtl/core/tfsm_pkg.sv
// tfsm_pkg: shared types, codes and reset values for the tank fill stall monitor
// no dependencies; imported by the step logic and the top level
`default_nettype none

package tfsm_pkg;

   // input item kinds
   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_FILL = 2'd1;
   localparam logic [1:0] MODE_STOP = 2'd2;

   // status codes
   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_STOPPED_FILL = 3'd1;
   localparam logic [2:0] STATUS_NOT_FILLING  = 3'd2;
   localparam logic [2:0] STATUS_NO_SOURCE    = 3'd3;
   localparam logic [2:0] STATUS_TANK_FULL    = 3'd4;

   // register indexes on the csr port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VOLUME       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_VOLUME       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANGE_TOLERANCE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANGE_INTERVAL  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HAS_SOURCE       = 3'd4;

   // register reset values
   localparam logic [15:0] MAX_VOLUME_RST       = 16'hFFFF;
   localparam logic [15:0] MIN_VOLUME_RST       = 16'd0;
   localparam logic [15:0] CHANGE_TOLERANCE_RST = 16'd1;
   localparam logic [31:0] CHANGE_INTERVAL_RST  = 32'd1000;
   localparam logic        HAS_SOURCE_RST       = 1'b1;

   typedef struct packed {
      logic [15:0] max_volume;
      logic [15:0] min_volume;
      logic [15:0] change_tolerance;
      logic [31:0] change_interval;
      logic        has_source;
   } cfg_type;

   typedef struct packed {
      logic        filling;
      logic        forced_flag;
      logic        change_seen;
      logic [31:0] ticks_since_start;
      logic [31:0] ticks_since_change;
      logic [15:0] previous_pressure;
   } state_type;

   localparam state_type STATE_RST = '{
      filling:            1'b0,
      forced_flag:        1'b0,
      change_seen:        1'b0,
      ticks_since_start:  32'd0,
      ticks_since_change: 32'd0,
      previous_pressure:  16'd0
   };

   typedef struct packed {
      logic [1:0]  mode;
      logic        force_req;
      logic [15:0] pressure;
      logic [15:0] volume;
   } req_type;

   typedef struct packed {
      logic       source_on;
      logic       source_forced;
      logic [2:0] status;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/tfsm_channels.sv
// tfsm_req_if and tfsm_rsp_if: valid/ready channels for requests and results
// no dependencies
`default_nettype none

interface tfsm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic        force_req;
   logic [15:0] pressure;
   logic [15:0] volume;

   modport source (output valid, mode, force_req, pressure, volume, input ready);
   modport sink (input valid, mode, force_req, pressure, volume, output ready);
endinterface

interface tfsm_rsp_if;
   logic       valid;
   logic       ready;
   logic       source_on;
   logic       source_forced;
   logic [2:0] status;

   modport source (output valid, source_on, source_forced, status, input ready);
   modport sink (input valid, source_on, source_forced, status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tfsm_step.sv
// tfsm_step: next state and result for one request, pure combinational logic
// depends on tfsm_pkg
`default_nettype none

module tfsm_step (
   input  tfsm_pkg::cfg_type   cfg,
   input  tfsm_pkg::state_type state_cur,
   input  tfsm_pkg::req_type   req,
   output tfsm_pkg::state_type state_nxt,
   output tfsm_pkg::rsp_type   rsp
);
   import tfsm_pkg::*;

   logic [31:0] tss_inc;
   logic [31:0] tsc_inc;
   logic [15:0] diff;
   logic        monitor;
   logic        at_max;
   logic        at_min;
   logic [2:0]  status;

   // saturating tick counters and pressure change magnitude
   assign tss_inc = (&state_cur.ticks_since_start) ? state_cur.ticks_since_start
                                                   : state_cur.ticks_since_start + 32'd1;
   assign tsc_inc = (&state_cur.ticks_since_change) ? state_cur.ticks_since_change
                                                    : state_cur.ticks_since_change + 32'd1;
   assign diff = (req.pressure >= state_cur.previous_pressure)
               ? req.pressure - state_cur.previous_pressure
               : state_cur.previous_pressure - req.pressure;
   assign monitor = !cfg.has_source || state_cur.filling;
   assign at_max  = req.volume >= cfg.max_volume;
   assign at_min  = req.volume <= cfg.min_volume;

   // per-request state update
   always_comb begin
      state_nxt = state_cur;
      status    = STATUS_OK;
      case (req.mode)
         MODE_TICK: begin
            state_nxt.ticks_since_start  = tss_inc;
            state_nxt.ticks_since_change = tsc_inc;
            if (monitor) begin
               if (diff >= cfg.change_tolerance) begin
                  state_nxt.change_seen        = 1'b1;
                  state_nxt.ticks_since_change = 32'd0;
               end else if (state_cur.change_seen) begin
                  if (tsc_inc >= cfg.change_interval) status = STATUS_STOPPED_FILL;
               end else if (tss_inc >= cfg.change_interval) begin
                  status = STATUS_NOT_FILLING;
               end
               state_nxt.previous_pressure = req.pressure;
            end
            // volume hysteresis on the source
            if (cfg.has_source) begin
               if (at_max) begin
                  state_nxt.filling     = 1'b0;
                  state_nxt.forced_flag = 1'b0;
               end else if (at_min) begin
                  state_nxt.change_seen       = 1'b0;
                  state_nxt.ticks_since_start = 32'd0;
                  state_nxt.filling           = 1'b1;
                  state_nxt.forced_flag       = 1'b0;
               end
            end
         end
         MODE_FILL: begin
            if (!cfg.has_source) begin
               status = STATUS_NO_SOURCE;
            end else if (!req.force_req && at_max) begin
               status = STATUS_TANK_FULL;
            end else begin
               state_nxt.change_seen       = 1'b0;
               state_nxt.ticks_since_start = 32'd0;
               state_nxt.filling           = 1'b1;
               state_nxt.forced_flag       = req.force_req;
            end
         end
         MODE_STOP: begin
            if (cfg.has_source) begin
               state_nxt.filling     = 1'b0;
               state_nxt.forced_flag = 1'b0;
            end
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

   // outputs reflect the state after this request
   assign rsp.source_on     = state_nxt.filling & cfg.has_source;
   assign rsp.source_forced = state_nxt.forced_flag & cfg.has_source;
   assign rsp.status        = status;

endmodule

`default_nettype wire

// File: rtl/core/tank_fill_stall_monitor_top.sv
// tank_fill_stall_monitor_top: csr registers, monitor state and result register
// depends on tfsm_pkg, tfsm_channels (tfsm_req_if, tfsm_rsp_if) and tfsm_step
`default_nettype none

// Tank fill stall monitor. Each request is a sample tick, a fill command or a
// stop command; one result comes back per request with the source enable, the
// force flag and a status code. The step logic reads the request and the
// monitor state, and the state and the result register load at the same edge.
// Requests are taken every cycle while the result register is empty or its
// result is being taken in that cycle, so the sustained rate is one request
// per clock, and each result is valid in the cycle after its request. The
// csr registers are written through csr_we/csr_index/csr_wdata and should only
// change while no request is in flight; indexes past has_source are ignored.
module tank_fill_stall_monitor_top (
   input  wire                                 clock,
   input  wire                                 reset,
   tfsm_req_if.sink                            req_chan,
   tfsm_rsp_if.source                          rsp_chan,
   input  wire                                 csr_we,
   input  wire  [tfsm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [tfsm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tfsm_pkg::*;

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   req_type   req;
   rsp_type   rsp_in;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   logic      req_take;

   // request side handshake
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign req.mode      = req_chan.mode;
   assign req.force_req = req_chan.force_req;
   assign req.pressure  = req_chan.pressure;
   assign req.volume    = req_chan.volume;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_volume       <= MAX_VOLUME_RST;
         cfg_ff.min_volume       <= MIN_VOLUME_RST;
         cfg_ff.change_tolerance <= CHANGE_TOLERANCE_RST;
         cfg_ff.change_interval  <= CHANGE_INTERVAL_RST;
         cfg_ff.has_source       <= HAS_SOURCE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_VOLUME:       cfg_ff.max_volume       <= csr_wdata[15:0];
            CSR_MIN_VOLUME:       cfg_ff.min_volume       <= csr_wdata[15:0];
            CSR_CHANGE_TOLERANCE: cfg_ff.change_tolerance <= csr_wdata[15:0];
            CSR_CHANGE_INTERVAL:  cfg_ff.change_interval  <= csr_wdata[31:0];
            CSR_HAS_SOURCE:       cfg_ff.has_source       <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // next state and result for the incoming request
   tfsm_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .req       (req),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   // monitor state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RST;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.source_on     = rsp_ff.source_on;
   assign rsp_chan.source_forced = rsp_ff.source_forced;
   assign rsp_chan.status        = rsp_ff.status;

endmodule

`default_nettype wire
